// ===== hdl/tgi_pkg.sv =====
// ----------------------------------------------------------------------------
// Trilinear grid interpolator package
// Shared widths, codes, types and helpers for the grid interpolator.
// ----------------------------------------------------------------------------
package tgi_pkg;

   localparam int GRID_N      = 16;               // nodes per axis
   localparam int AXIS_W      = $clog2(GRID_N);   // index width per axis
   localparam int SIZE_W      = 5;
   localparam int VALUE_WIDTH = 32;
   localparam int POS_W       = 32;
   localparam int INV_W       = 32;
   localparam int G_W         = 48;               // grid-space coordinate, Q.16
   localparam int WEIGHT_W    = G_W + 1;          // weight, Q.16, signed
   localparam int N_BANKS     = 8;                // one bank per index parity triple
   localparam int BANK_AW     = 3 * (AXIS_W - 1);
   localparam int BANK_DEPTH  = 1 << BANK_AW;
   localparam int LERP_STAGES = 4;
   localparam int N_STAGES    = 4 + 3 * LERP_STAGES;
   localparam int CSR_AW      = 4;
   localparam int CSR_DW      = 32;

   typedef logic signed [VALUE_WIDTH-1:0] value_type;
   typedef logic signed [WEIGHT_W-1:0]    weight_type;
   typedef logic [LERP_STAGES-1:0]        lerp_adv_type;

   typedef enum logic {
      CMD_WRITE = 1'b0,
      CMD_QUERY = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      REG_INV_SPACING = 2'd0,
      REG_SIZE_X      = 2'd1,
      REG_SIZE_Y      = 2'd2,
      REG_SIZE_Z      = 2'd3
   } csr_reg_type;

   // Last usable node index for a size register: zero acts as one,
   // oversize acts as the full grid.
   function automatic logic [AXIS_W-1:0] eff_last(logic [SIZE_W-1:0] sz);
      logic [AXIS_W-1:0] r;
      if (sz == '0) begin
         r = '0;
      end else if (sz > SIZE_W'(GRID_N)) begin
         r = AXIS_W'(GRID_N - 1);
      end else begin
         r = AXIS_W'(sz - 1'b1);
      end
      return r;
   endfunction

endpackage

// ===== hdl/tgi_req_if.sv =====
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying grid writes and interpolation queries.
// ----------------------------------------------------------------------------
interface tgi_req_if import tgi_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     command;
   logic [AXIS_W-1:0]        write_x;
   logic [AXIS_W-1:0]        write_y;
   logic [AXIS_W-1:0]        write_z;
   logic signed [31:0]       write_value;
   logic signed [POS_W-1:0]  pos_x;
   logic signed [POS_W-1:0]  pos_y;
   logic signed [POS_W-1:0]  pos_z;

   modport source (output valid, command, write_x, write_y, write_z, write_value,
                   pos_x, pos_y, pos_z, input ready);
   modport sink   (input valid, command, write_x, write_y, write_z, write_value,
                   pos_x, pos_y, pos_z, output ready);
endinterface

// ===== hdl/tgi_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying interpolated results.
// ----------------------------------------------------------------------------
interface tgi_rsp_if import tgi_pkg::*; ();
   logic               valid;
   logic               ready;
   logic signed [31:0] interpolated;

   modport source (output valid, interpolated, input ready);
   modport sink   (input valid, interpolated, output ready);
endinterface

// ===== hdl/tgi_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tgi_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== hdl/tgi_lerp.sv =====
// ----------------------------------------------------------------------------
// Pipelined linear blend
// a + floor((b - a) * w / 2^16), saturated, over four register stages.
// ----------------------------------------------------------------------------
module tgi_lerp import tgi_pkg::*; (
   input  logic         clock,
   input  lerp_adv_type adv,
   input  value_type    a_in,
   input  value_type    b_in,
   input  weight_type   w_in,
   output value_type    y_out
);

   localparam int DIFF_W = VALUE_WIDTH + 1;
   localparam int WLO_W  = 25;
   localparam int WHI_W  = WEIGHT_W - WLO_W;
   localparam int PLO_W  = DIFF_W + WLO_W;
   localparam int PHI_W  = DIFF_W + WHI_W;
   localparam int SUM_W  = DIFF_W + WEIGHT_W;
   localparam int Q_W    = SUM_W - 16;
   localparam int QC_W   = DIFF_W + 1;      // clip at 2^DIFF_W, still saturates
   localparam int R_W    = QC_W + 2;

   // stage 1: difference and magnitudes
   logic signed [DIFF_W-1:0] diff;
   logic [DIFF_W-1:0]        dmag_in;
   logic [WEIGHT_W-1:0]      wmag_in;
   value_type                a1_ff;
   logic [DIFF_W-1:0]        dmag_ff;
   logic [WEIGHT_W-1:0]      wmag_ff;
   logic                     neg1_ff;

   assign diff    = $signed({b_in[VALUE_WIDTH-1], b_in}) - $signed({a_in[VALUE_WIDTH-1], a_in});
   assign dmag_in = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
   assign wmag_in = w_in[WEIGHT_W-1] ? WEIGHT_W'(-w_in) : WEIGHT_W'(w_in);

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         a1_ff   <= a_in;
         dmag_ff <= dmag_in;
         wmag_ff <= wmag_in;
         neg1_ff <= diff[DIFF_W-1] ^ w_in[WEIGHT_W-1];
      end
   end

   // stage 2: two partial products
   value_type        a2_ff;
   logic [PLO_W-1:0] plo_ff;
   logic [PHI_W-1:0] phi_ff;
   logic             neg2_ff;

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         a2_ff   <= a1_ff;
         plo_ff  <= PLO_W'(dmag_ff * wmag_ff[WLO_W-1:0]);
         phi_ff  <= PHI_W'(dmag_ff * wmag_ff[WEIGHT_W-1:WLO_W]);
         neg2_ff <= neg1_ff;
      end
   end

   // stage 3: combine, floor-round the quotient by 2^16, clip
   logic [SUM_W-1:0] sum;
   logic [Q_W-1:0]   q;
   logic [QC_W-1:0]  qc_in;
   value_type        a3_ff;
   logic [QC_W-1:0]  qc_ff;
   logic             neg3_ff;

   always_comb begin
      sum = SUM_W'(plo_ff) + (SUM_W'(phi_ff) << WLO_W);
      q   = sum[SUM_W-1:16] + Q_W'(neg2_ff && (sum[15:0] != '0));
      if (q[Q_W-1:DIFF_W] != '0) begin
         qc_in = QC_W'(1) << DIFF_W;
      end else begin
         qc_in = QC_W'(q[DIFF_W-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         a3_ff   <= a2_ff;
         qc_ff   <= qc_in;
         neg3_ff <= neg2_ff;
      end
   end

   // stage 4: add and saturate
   logic signed [R_W-1:0] qs;
   logic signed [R_W-1:0] r;
   value_type             y_in;
   value_type             y_ff;

   always_comb begin
      qs = neg3_ff ? -$signed({2'b00, qc_ff}) : $signed({2'b00, qc_ff});
      r  = R_W'(a3_ff) + qs;
      if (r > R_W'(signed'({1'b0, {(VALUE_WIDTH-1){1'b1}}}))) begin
         y_in = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
      end else if (r < -R_W'(signed'({1'b0, 1'b1, {(VALUE_WIDTH-1){1'b0}}}))) begin
         y_in = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
      end else begin
         y_in = r[VALUE_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         y_ff <= y_in;
      end
   end

   assign y_out = y_ff;

endmodule

// ===== hdl/trilinear_grid_interpolator.sv =====
// ----------------------------------------------------------------------------
// Trilinear grid interpolator
// 16x16x16 grid of Q16.16 samples in eight parity banks; queries blend the
// eight surrounding samples through a sixteen-stage pipeline.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle while results are taken; the eight parity
// banks deliver all corners of a cell in one read, and a stall holds only the
// full stages back to the nearest empty one, so bubbles collapse.
// Writes land in the grid at the bank stage and give no result.
// Reset: synchronous, clears valid bits and loads the register defaults;
// grid contents stay undefined until written.
// ----------------------------------------------------------------------------
module trilinear_grid_interpolator import tgi_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   tgi_req_if.sink           req_chan,
   tgi_rsp_if.source         rsp_chan,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   localparam int LAST = N_STAGES - 1;

   // ---------------- configuration registers ----------------
   logic [INV_W-1:0]  inv_ff;
   logic [SIZE_W-1:0] size_ff [3];
   logic              csr_wr;
   logic [AXIS_W-1:0] last_idx [3];

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_ff     <= INV_W'(65536);
         size_ff[0] <= SIZE_W'(GRID_N);
         size_ff[1] <= SIZE_W'(GRID_N);
         size_ff[2] <= SIZE_W'(GRID_N);
      end else if (csr_wr) begin
         case (csr_reg_type'(csr_paddr[3:2]))
            REG_INV_SPACING: inv_ff     <= csr_pwdata[INV_W-1:0];
            REG_SIZE_X:      size_ff[0] <= csr_pwdata[SIZE_W-1:0];
            REG_SIZE_Y:      size_ff[1] <= csr_pwdata[SIZE_W-1:0];
            REG_SIZE_Z:      size_ff[2] <= csr_pwdata[SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_reg_type'(csr_paddr[3:2]))
         REG_INV_SPACING: csr_prdata = CSR_DW'(inv_ff);
         REG_SIZE_X:      csr_prdata = CSR_DW'(size_ff[0]);
         REG_SIZE_Y:      csr_prdata = CSR_DW'(size_ff[1]);
         REG_SIZE_Z:      csr_prdata = CSR_DW'(size_ff[2]);
         default:         csr_prdata = '0;
      endcase
   end

   for (genvar a = 0; a < 3; a++) begin : g_last
      assign last_idx[a] = eff_last(size_ff[a]);
   end

   // ---------------- stage valids and advance chain ----------------
   // A stage loads when it is empty or its successor loads too, so bubbles
   // collapse; the chain runs combinationally from the result ready to the
   // input ready.
   logic [N_STAGES-1:0] v_ff;
   logic [N_STAGES-1:0] adv;
   logic [N_STAGES-1:0] v_in;

   always_comb begin
      adv[LAST] = !v_ff[LAST] || rsp_chan.ready;
      for (int k = LAST - 1; k >= 0; k--) begin
         adv[k] = !v_ff[k] || adv[k+1];
      end
   end

   assign req_chan.ready = adv[0];

   // ---------------- stage 0: capture word ----------------
   logic                    cmd0_ff;
   logic [AXIS_W-1:0]       wx0_ff, wy0_ff, wz0_ff;
   value_type               wv0_ff;
   logic signed [POS_W-1:0] pos0_ff [3];

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         cmd0_ff    <= req_chan.command;
         wx0_ff     <= req_chan.write_x;
         wy0_ff     <= req_chan.write_y;
         wz0_ff     <= req_chan.write_z;
         wv0_ff     <= req_chan.write_value;
         pos0_ff[0] <= req_chan.pos_x;
         pos0_ff[1] <= req_chan.pos_y;
         pos0_ff[2] <= req_chan.pos_z;
      end
   end

   // ---------------- stage 1: scale into grid space ----------------
   // g = floor(pos * inv / 2^16); the arithmetic shift gives the floor.
   logic                  cmd1_ff;
   logic [AXIS_W-1:0]     wx1_ff, wy1_ff, wz1_ff;
   value_type             wv1_ff;
   logic signed [63:0]    prod [3];
   logic signed [G_W-1:0] g1_ff [3];

   for (genvar a = 0; a < 3; a++) begin : g_scale
      assign prod[a] = 64'(pos0_ff[a]) * $signed({32'd0, inv_ff});
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         cmd1_ff <= cmd0_ff;
         wx1_ff  <= wx0_ff;
         wy1_ff  <= wy0_ff;
         wz1_ff  <= wz0_ff;
         wv1_ff  <= wv0_ff;
         for (int a = 0; a < 3; a++) begin
            g1_ff[a] <= prod[a][63:16];
         end
      end
   end

   // ---------------- stage 2: base and neighbor indices ----------------
   logic                  cmd2_ff;
   logic [AXIS_W-1:0]     wx2_ff, wy2_ff, wz2_ff;
   value_type             wv2_ff;
   logic signed [G_W-1:0] g2_ff [3];
   logic [AXIS_W-1:0]     base_in [3];
   logic [AXIS_W-1:0]     next_in [3];
   logic [AXIS_W-1:0]     base_ff [3];
   logic [AXIS_W-1:0]     next_ff [3];

   always_comb begin
      logic signed [G_W-1:0] t;
      logic signed [31:0]    braw;
      for (int a = 0; a < 3; a++) begin
         t    = g1_ff[a] - G_W'(32768);
         braw = t[G_W-1:16];
         // clamp below to zero, above to the last node in use
         if (braw[31]) begin
            base_in[a] = '0;
         end else if (braw > 32'(last_idx[a])) begin
            base_in[a] = last_idx[a];
         end else begin
            base_in[a] = braw[AXIS_W-1:0];
         end
         next_in[a] = (base_in[a] == last_idx[a]) ? base_in[a] : base_in[a] + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         cmd2_ff <= cmd1_ff;
         wx2_ff  <= wx1_ff;
         wy2_ff  <= wy1_ff;
         wz2_ff  <= wz1_ff;
         wv2_ff  <= wv1_ff;
         for (int a = 0; a < 3; a++) begin
            g2_ff[a]   <= g1_ff[a];
            base_ff[a] <= base_in[a];
            next_ff[a] <= next_in[a];
         end
      end
   end

   // ---------------- stage 3: grid banks and weights ----------------
   // Bank number is the parity triple {x[0], y[0], z[0]}; a cell's two nodes
   // per axis always have opposite parity unless clamped to the same node.
   logic                   bank_go;
   logic                   wr_go;
   logic [N_BANKS-1:0]     bank_we;
   logic [BANK_AW-1:0]     bank_waddr;
   logic [BANK_AW-1:0]     bank_raddr [N_BANKS];
   value_type              bank_rd [N_BANKS];
   weight_type             w_in [3];
   weight_type             w3_ff [3];
   logic                   pb_ff [3];    // parity of base node
   logic                   pn_ff [3];    // parity of neighbor node

   assign bank_go    = adv[3] && v_ff[2];
   assign wr_go      = bank_go && (cmd_type'(cmd2_ff) == CMD_WRITE);
   assign bank_waddr = {wx2_ff[AXIS_W-1:1], wy2_ff[AXIS_W-1:1], wz2_ff[AXIS_W-1:1]};

   for (genvar bk = 0; bk < N_BANKS; bk++) begin : g_bank
      logic [AXIS_W-1:0] sel [3];
      always_comb begin
         for (int a = 0; a < 3; a++) begin
            // pick whichever of base/neighbor has this bank's parity
            sel[a] = (base_ff[a][0] == bk[2-a]) ? base_ff[a] : next_ff[a];
         end
      end
      assign bank_raddr[bk] = {sel[0][AXIS_W-1:1], sel[1][AXIS_W-1:1], sel[2][AXIS_W-1:1]};
      assign bank_we[bk]    = wr_go && ({wx2_ff[0], wy2_ff[0], wz2_ff[0]} == 3'(bk));

      tgi_ram #(
         .WIDTH (VALUE_WIDTH),
         .DEPTH (BANK_DEPTH)
      ) u_bank (
         .clock (clock),
         .we    (bank_we[bk]),
         .waddr (bank_waddr),
         .wdata (wv2_ff),
         .re    (adv[3]),
         .raddr (bank_raddr[bk]),
         .rdata (bank_rd[bk])
      );
   end

   // weight of the upper node, from the unclamped coordinate
   for (genvar a = 0; a < 3; a++) begin : g_weight
      assign w_in[a] = WEIGHT_W'(g2_ff[a])
                     - $signed({1'b0, (WEIGHT_W-1)'({base_ff[a], 16'h8000})});
   end

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         for (int a = 0; a < 3; a++) begin
            w3_ff[a] <= w_in[a];
            pb_ff[a] <= base_ff[a][0];
            pn_ff[a] <= next_ff[a][0];
         end
      end
   end

   // ---------------- corner select ----------------
   // corner code {cx, cy, cz}: 0 takes the base node, 1 the neighbor
   value_type corner [8];

   always_comb begin
      logic [2:0] bsel;
      for (int c = 0; c < 8; c++) begin
         bsel[2]   = c[2] ? pn_ff[0] : pb_ff[0];
         bsel[1]   = c[1] ? pn_ff[1] : pb_ff[1];
         bsel[0]   = c[0] ? pn_ff[2] : pb_ff[2];
         corner[c] = bank_rd[bsel];
      end
   end

   // ---------------- weight delay lines ----------------
   weight_type wy_d_ff [LERP_STAGES];
   weight_type wz_d_ff [2 * LERP_STAGES];

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         wy_d_ff[0] <= w3_ff[1];
         wz_d_ff[0] <= w3_ff[2];
      end
      for (int s = 1; s < LERP_STAGES; s++) begin
         if (adv[4+s]) begin
            wy_d_ff[s] <= wy_d_ff[s-1];
         end
      end
      for (int s = 1; s < 2 * LERP_STAGES; s++) begin
         if (adv[4+s]) begin
            wz_d_ff[s] <= wz_d_ff[s-1];
         end
      end
   end

   // ---------------- blend: four along x, two along y, one along z ----------------
   value_type c00, c10, c01, c11, c0, c1, result;

   tgi_lerp u_lx00 (.clock(clock), .adv(adv[7:4]), .a_in(corner[3'b000]),
                    .b_in(corner[3'b100]), .w_in(w3_ff[0]), .y_out(c00));
   tgi_lerp u_lx10 (.clock(clock), .adv(adv[7:4]), .a_in(corner[3'b010]),
                    .b_in(corner[3'b110]), .w_in(w3_ff[0]), .y_out(c10));
   tgi_lerp u_lx01 (.clock(clock), .adv(adv[7:4]), .a_in(corner[3'b001]),
                    .b_in(corner[3'b101]), .w_in(w3_ff[0]), .y_out(c01));
   tgi_lerp u_lx11 (.clock(clock), .adv(adv[7:4]), .a_in(corner[3'b011]),
                    .b_in(corner[3'b111]), .w_in(w3_ff[0]), .y_out(c11));

   tgi_lerp u_ly0 (.clock(clock), .adv(adv[11:8]), .a_in(c00), .b_in(c10),
                   .w_in(wy_d_ff[LERP_STAGES-1]), .y_out(c0));
   tgi_lerp u_ly1 (.clock(clock), .adv(adv[11:8]), .a_in(c01), .b_in(c11),
                   .w_in(wy_d_ff[LERP_STAGES-1]), .y_out(c1));

   tgi_lerp u_lz (.clock(clock), .adv(adv[15:12]), .a_in(c0), .b_in(c1),
                  .w_in(wz_d_ff[2*LERP_STAGES-1]), .y_out(result));

   // ---------------- valid bits ----------------
   // Writes retire at the bank stage; only queries travel past it.
   always_comb begin
      v_in[0] = req_chan.valid;
      for (int k = 1; k < N_STAGES; k++) begin
         v_in[k] = v_ff[k-1];
      end
      v_in[3] = v_ff[2] && (cmd_type'(cmd2_ff) == CMD_QUERY);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int k = 0; k < N_STAGES; k++) begin
            if (adv[k]) begin
               v_ff[k] <= v_in[k];
            end
         end
      end
   end

   assign rsp_chan.valid        = v_ff[LAST];
   assign rsp_chan.interpolated = result;

   // ---------------- assertions ----------------
   a_ready_when_out_empty: assert property (@(posedge clock) disable iff (reset)
      !v_ff[LAST] |-> req_chan.ready)
      else $error("input stalled while output register is empty");

   a_one_bank_write: assert property (@(posedge clock) disable iff (reset)
      $onehot0(bank_we))
      else $error("more than one grid bank written in a cycle");

   a_write_no_result: assert property (@(posedge clock) disable iff (reset)
      (adv[3] && v_ff[2] && (cmd_type'(cmd2_ff) == CMD_WRITE)) |=> !v_ff[3])
      else $error("grid write entered the blend pipeline");

   a_neighbor_order: assert property (@(posedge clock) disable iff (reset)
      v_ff[2] |-> (next_ff[0] >= base_ff[0]) && (next_ff[1] >= base_ff[1])
                  && (next_ff[2] >= base_ff[2]))
      else $error("neighbor index below base index");

endmodule

// ===== bench/trilinear_grid_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Trilinear grid checker
// Watches the request, response and register ports, keeps a shadow grid
// and register set, predicts each interpolated word and compares it.
// ----------------------------------------------------------------------------
module trilinear_grid_checker import tgi_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   tgi_req_if                req_chan,
   tgi_rsp_if                rsp_chan,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   input  logic              csr_pready,
   output int                fail_count,
   output int                pending_count
);

   localparam logic signed [127:0] PROD_LIM = 128'sd1 <<< 62;

   logic signed [63:0] shadow_grid [GRID_N*GRID_N*GRID_N];
   logic [31:0]        inv_spacing;
   logic [4:0]         nodes_x, nodes_y, nodes_z;
   logic signed [31:0] blend_queue [$];

   function automatic logic signed [63:0] q16_mul(logic signed [63:0] a, logic signed [63:0] b);
      logic signed [127:0] wa, wb, p;
      wa = a;
      wb = b;
      p = (wa * wb) >>> 16;
      if (p > PROD_LIM) p = PROD_LIM;
      if (p < -PROD_LIM) p = -PROD_LIM;
      return p[63:0];
   endfunction

   function automatic logic signed [63:0] clip32(logic signed [63:0] v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic logic signed [63:0] blend(logic signed [63:0] a, logic signed [63:0] b,
                                                logic signed [63:0] w);
      return clip32(a + q16_mul(b - a, w));
   endfunction

   function automatic int nodes_in_use(logic [4:0] r);
      if (r == 0) return 1;
      if (r > GRID_N) return GRID_N;
      return r;
   endfunction

   // base node, upper node and weight along one axis
   task automatic locate(input logic signed [31:0] pos, input int n,
                         output int lo, output int hi, output logic signed [63:0] w);
      logic signed [63:0] g, b;
      g = q16_mul(pos, {32'b0, inv_spacing});
      b = (g - 64'sd32768) >>> 16;
      if (b < 0) b = 0;
      if (b > n - 1) b = n - 1;
      lo = int'(b);
      hi = (lo + 1 > n - 1) ? n - 1 : lo + 1;
      w = g - ((b <<< 16) + 64'sd32768);
   endtask

   function automatic logic signed [63:0] at(int x, int y, int z);
      return shadow_grid[(x * GRID_N + y) * GRID_N + z];
   endfunction

   task automatic predict_query(input logic signed [31:0] px, py, pz);
      int i0, i1, j0, j1, k0, k1;
      logic signed [63:0] wx, wy, wz, c00, c10, c01, c11, c0, c1;
      locate(px, nodes_in_use(nodes_x), i0, i1, wx);
      locate(py, nodes_in_use(nodes_y), j0, j1, wy);
      locate(pz, nodes_in_use(nodes_z), k0, k1, wz);
      c00 = blend(at(i0, j0, k0), at(i1, j0, k0), wx);
      c10 = blend(at(i0, j1, k0), at(i1, j1, k0), wx);
      c01 = blend(at(i0, j0, k1), at(i1, j0, k1), wx);
      c11 = blend(at(i0, j1, k1), at(i1, j1, k1), wx);
      c0  = blend(c00, c10, wy);
      c1  = blend(c01, c11, wy);
      blend_queue.push_back(32'(clip32(blend(c0, c1, wz))));
   endtask

   always @(posedge clock) begin
      logic signed [31:0] want;
      if (reset) begin
         inv_spacing <= 32'd65536;
         nodes_x <= 5'd16;
         nodes_y <= 5'd16;
         nodes_z <= 5'd16;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_paddr[1:0] == 2'b00) begin
            case (csr_reg_type'(csr_paddr[3:2]))
               REG_INV_SPACING: inv_spacing <= csr_pwdata;
               REG_SIZE_X:      nodes_x <= csr_pwdata[4:0];
               REG_SIZE_Y:      nodes_y <= csr_pwdata[4:0];
               REG_SIZE_Z:      nodes_z <= csr_pwdata[4:0];
               default: ;
            endcase
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (blend_queue.size() == 0) begin
               fail_count <= fail_count + 1;
               if (fail_count < 10)
                  $display("unexpected word: interpolated=%0d", rsp_chan.interpolated);
            end else begin
               want = blend_queue.pop_front();
               if (rsp_chan.interpolated !== want) begin
                  fail_count <= fail_count + 1;
                  if (fail_count < 10)
                     $display("mismatch: interpolated expected %0d got %0d",
                              want, rsp_chan.interpolated);
               end
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            if (cmd_type'(req_chan.command) == CMD_WRITE)
               shadow_grid[(int'(req_chan.write_x) * GRID_N + int'(req_chan.write_y)) * GRID_N
                           + int'(req_chan.write_z)] = req_chan.write_value;
            else
               predict_query(req_chan.pos_x, req_chan.pos_y, req_chan.pos_z);
         end
      end
      pending_count <= blend_queue.size();
   end

   initial begin
      fail_count = 0;
      pending_count = 0;
   end

endmodule

// ===== bench/trilinear_grid_interpolator_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Trilinear grid interpolator testbench
// Preloads the grid, runs directed and random writes and queries under
// several register settings and idle patterns; the checker scores results.
// ----------------------------------------------------------------------------
module trilinear_grid_interpolator_test;
   import tgi_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES  = 24;   // margin beyond the pipeline tail

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_psel = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite = 1'b0;
   logic [CSR_AW-1:0] csr_paddr = '0;
   logic [CSR_DW-1:0] csr_pwdata = '0;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;
   int                fail_count;
   int                pending_count;
   int                tx_idle_pct = 0;
   int                rx_idle_pct = 0;
   bit                rsp_hold = 1'b0;
   int                quiet_cycles = 0;

   tgi_req_if req_chan ();
   tgi_rsp_if rsp_chan ();

   trilinear_grid_interpolator u_top (
      .clock(clock), .reset(reset), .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   trilinear_grid_checker u_checker (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_pready(csr_pready),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      req_chan.valid = 1'b0;
      req_chan.command = CMD_WRITE;
      req_chan.write_x = '0;
      req_chan.write_y = '0;
      req_chan.write_z = '0;
      req_chan.write_value = '0;
      req_chan.pos_x = '0;
      req_chan.pos_y = '0;
      req_chan.pos_z = '0;
      rsp_chan.ready = 1'b0;
   end

   // Receiver: stall at random, or hold off entirely while rsp_hold is set.
   always @(posedge clock) begin
      rsp_chan.ready <= !rsp_hold && ($urandom_range(99) >= rx_idle_pct);
   end

   // Watchdog: count cycles in which no word moves on either channel.
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Offer one word, idling first at random, and hold it until accepted.
   task automatic push_word(input cmd_type cmd, input logic [3:0] wx, wy, wz,
                            input logic [31:0] value, px, py, pz);
      bit taken;
      while ($urandom_range(99) < tx_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.command <= cmd;
      req_chan.write_x <= wx;
      req_chan.write_y <= wy;
      req_chan.write_z <= wz;
      req_chan.write_value <= value;
      req_chan.pos_x <= px;
      req_chan.pos_y <= py;
      req_chan.pos_z <= pz;
      // sample ready mid-cycle, where it is stable
      do begin
         @(negedge clock);
         taken = req_chan.ready;
         @(posedge clock);
      end while (!taken);
   endtask

   task automatic write_sample(input logic [3:0] x, y, z, input logic [31:0] v);
      push_word(CMD_WRITE, x, y, z, v, $urandom, $urandom, $urandom);
   endtask

   task automatic query(input logic [31:0] px, py, pz);
      push_word(CMD_QUERY, $urandom, $urandom, $urandom, $urandom, px, py, pz);
   endtask

   // Drop valid, wait out every expected word and the pipeline tail.
   task automatic drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input csr_reg_type idx, input logic [31:0] v);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_AW'(idx) << 2;
      csr_pwdata <= v;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input logic [31:0] inv, input logic [4:0] sx, sy, sz);
      csr_write(REG_INV_SPACING, inv);
      csr_write(REG_SIZE_X, {27'b0, sx});
      csr_write(REG_SIZE_Y, {27'b0, sy});
      csr_write(REG_SIZE_Z, {27'b0, sz});
   endtask

   function automatic logic [31:0] any_sample();
      case ($urandom_range(9))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2, 3: return $urandom;
         default: return 32'($signed($urandom_range(200 << 16)) - (100 << 16));
      endcase
   endfunction

   function automatic logic [4:0] any_size();
      case ($urandom_range(7))
         0: return 5'd0;
         1: return 5'd1;
         2: return 5'd16;
         3: return 5'd31;
         default: return 5'($urandom_range(1, 16));
      endcase
   endfunction

   // Position mostly a little beyond the grid span in world units,
   // sometimes any 32-bit value.
   function automatic logic [31:0] any_pos(input logic [31:0] inv);
      longint span;
      if ($urandom_range(9) == 0 || inv == 0) return $urandom;
      span = $signed({32'b0, $urandom_range(20 << 16)}) - longint'(2 << 16);
      span = (span <<< 16) / longint'(inv);
      if (span > 64'sd2147483647) span = 64'sd2147483647;
      if (span < -64'sd2147483648) span = -64'sd2147483648;
      return span[31:0];
   endfunction

   // One random phase: several register settings, mostly queries.
   task automatic random_phase(input int words);
      logic [31:0] inv;
      for (int n = 0; n < words; n++) begin
         if (n % 100 == 0) begin
            drain();
            case ($urandom_range(5))
               0: inv = 32'd1;
               1: inv = 32'hFFFF_FFFF;
               2: inv = 32'd65536;
               3: inv = $urandom;
               default: inv = $urandom_range(16384, 262144);
            endcase
            configure(inv, any_size(), any_size(), any_size());
         end
         if ($urandom_range(99) < 30)
            write_sample($urandom, $urandom, $urandom, any_sample());
         else
            query(any_pos(inv), any_pos(inv), any_pos(inv));
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Preload every node so no query reads an unwritten sample.
      for (int i = 0; i < GRID_N * GRID_N * GRID_N; i++)
         write_sample(4'(i >> 8), 4'(i >> 4), 4'(i), any_sample());
      drain();

      // Directed: extreme samples, positions and register values.
      configure(32'd65536, 5'd16, 5'd16, 5'd16);
      write_sample(4'd0, 4'd0, 4'd0, 32'h8000_0000);
      write_sample(4'd1, 4'd0, 4'd0, 32'h7FFF_FFFF);
      write_sample(4'd15, 4'd15, 4'd15, 32'h7FFF_FFFF);
      write_sample(4'd14, 4'd15, 4'd15, 32'h8000_0000);
      query(32'd0, 32'd0, 32'd0);
      query(32'd32768, 32'd32768, 32'd32768);
      query(32'h0001_0000, 32'd40000, 32'd98304);
      query(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      query(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      query(32'h000F_8000, 32'h000F_8000, 32'h000F_0000);
      query(32'hFFFF_0000, 32'h0002_0000, 32'h0010_8000);
      drain();
      // zero size acts as one, oversize as the full grid
      configure(32'hFFFF_FFFF, 5'd0, 5'd31, 5'd1);
      query(32'h0000_8000, 32'h0000_0001, 32'hFFFF_FFFF);
      query(32'h7FFF_FFFF, 32'h8000_0000, 32'd0);
      query(32'h0000_0003, 32'h0000_7FFF, 32'h0123_4567);
      drain();
      configure(32'd1, 5'd2, 5'd16, 5'd17);
      query(32'h7FFF_FFFF, 32'h8000_0000, 32'h4000_0000);
      query(32'd0, 32'hC000_0000, 32'h7FFF_FFFF);
      drain();

      // Random: sender idles 20%, receiver 76%; then swapped; then none.
      tx_idle_pct = 20;
      rx_idle_pct = 76;
      random_phase(430);
      drain();
      tx_idle_pct = 76;
      rx_idle_pct = 20;
      random_phase(430);
      drain();
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      // hold off the receiver long enough to fill the pipeline and stall input
      fork
         begin
            rsp_hold = 1'b1;
            repeat (300) @(posedge clock);
            rsp_hold = 1'b0;
         end
      join_none
      random_phase(440);
      drain();

      if (fail_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
